FILE: design/tvdt_pkg.sv
package tvdt_pkg;

  localparam int NUMBER_BITS_DEF = 61;
  localparam int MAX_DIGITS_DEF  = 19;

  localparam logic [2:0]  TAG_NUMBER = 3'd1;
  localparam logic [63:0] WORD_FALSE = 64'd0;
  localparam logic [63:0] WORD_NULL  = 64'd8;
  localparam logic [63:0] WORD_TRUE  = 64'd16;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_NONE  = 8'h00;

  typedef enum logic [1:0] {
    TXT_FALSE = 2'd0,
    TXT_NULL  = 2'd1,
    TXT_TRUE  = 2'd2
  } txt_t;

  typedef struct packed {
    logic load;
    logic shift_digit;
  } dab_ctrl_t;

  typedef struct packed {
    logic busy;
    logic ovf;
  } dab_stat_t;

  // constant texts, left aligned
  function automatic logic [7:0] txt_char(txt_t sel, logic [2:0] idx);
    logic [39:0] s;
    begin
      case (sel)
        TXT_FALSE: s = "false";
        TXT_NULL:  s = {"null", 8'h00};
        TXT_TRUE:  s = {"true", 8'h00};
        default:   s = '0;
      endcase
      txt_char = s[8 * (4 - int'(idx)) +: 8];
    end
  endfunction

  function automatic logic [2:0] txt_last(txt_t sel);
    begin
      case (sel)
        TXT_FALSE: txt_last = 3'd4;
        TXT_NULL:  txt_last = 3'd3;
        TXT_TRUE:  txt_last = 3'd3;
        default:   txt_last = 3'd3;
      endcase
    end
  endfunction

endpackage

FILE: design/tvdt_dabble.sv
module tvdt_dabble
  import tvdt_pkg::*;
#(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF,
  parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dab_ctrl_t              ctrl,
  input  logic [NUMBER_BITS-1:0] mag,
  output dab_stat_t              stat,
  output logic [3:0]             digit
);

  localparam int BW = 4 * MAX_DIGITS;
  localparam int CW = $clog2(NUMBER_BITS + 1);

  logic [NUMBER_BITS-1:0] mag_sr;
  logic [BW-1:0]          bcd;
  logic [BW-1:0]          adj;
  logic [CW-1:0]          cnt;
  logic                   busy;
  logic                   ovf;

  // add-3 correction on each digit before the shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctrl.load) begin
      busy <= 1'b1;
    end else if (busy && cnt == CW'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mag_sr <= mag;
      bcd    <= '0;
      cnt    <= CW'(NUMBER_BITS);
      ovf    <= 1'b0;
    end else if (busy) begin
      mag_sr <= mag_sr << 1;
      bcd    <= {adj[BW-2:0], mag_sr[NUMBER_BITS-1]};
      ovf    <= ovf | adj[BW-1];
      cnt    <= cnt - CW'(1);
    end else if (ctrl.shift_digit) begin
      bcd <= {bcd[BW-5:0], 4'd0};
    end
  end

  assign stat.busy = busy;
  assign stat.ovf  = ovf;
  assign digit     = bcd[BW-1 -: 4];

endmodule

FILE: design/tagged_value_to_decimal_text.sv
// Tagged value word to ASCII decimal text.
// Input channel s_axis: one 64-bit tagged value word per item.
// Output channel m_axis: one ASCII character per item, first character
// first; tlast marks the final character of a value, tuser flags a word
// that is not a number or a constant (one item, character 0).
// The words 0, 8 and 16 give "false", "null" and "true", one character a
// cycle while the output register is free. A number (tag 1) is converted
// by a bit-serial double-dabble shift register, then the digits are scanned
// from the top, leading zeros skipped, with a '-' in front for a negative
// number; each digit waits while the output register is not free.
// Input is taken only when the block is idle and the output register is
// free. The output register holds its item while m_axis_tready is low and
// the block waits; nothing is lost. Reset is synchronous, clears the
// sequencer and the output valid; no clearing pass is needed.
module tagged_value_to_decimal_text
  import tvdt_pkg::*;
#(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF,
  parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // value_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // text_char
  output logic        m_axis_tlast,   // last_char
  output logic        m_axis_tuser    // unsupported
);

  localparam int EW = $clog2(MAX_DIGITS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_SIGN = 5'b00100,
    S_DIG  = 5'b01000,
    S_TEXT = 5'b10000
  } state_t;

  state_t                 state;
  state_t                 state_next;
  dab_ctrl_t              ctrl;
  dab_stat_t              stat;
  logic [3:0]             digit;
  logic [NUMBER_BITS-1:0] field;
  logic [NUMBER_BITS-1:0] mag;
  logic                   neg;
  logic [EW-1:0]          ecnt;
  logic                   started;
  txt_t                   txt_sel;
  logic [2:0]             txt_idx;
  logic                   can_put;
  logic                   put;
  logic [7:0]             put_char;
  logic                   put_last;
  logic                   put_uns;
  logic                   accept;
  logic                   dig_last;
  logic                   dig_show;

  assign field    = s_axis_tdata[3 +: NUMBER_BITS];
  assign mag      = field[NUMBER_BITS-1] ? (~field + NUMBER_BITS'(1)) : field;
  assign can_put  = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && can_put;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign dig_last = (ecnt == EW'(MAX_DIGITS - 1));
  assign dig_show = started || (digit != 4'd0) || stat.ovf || dig_last;

  tvdt_dabble #(
    .NUMBER_BITS(NUMBER_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dabble (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .mag  (mag),
    .stat (stat),
    .digit(digit)
  );

  always_comb begin
    state_next       = state;
    ctrl.load        = 1'b0;
    ctrl.shift_digit = 1'b0;
    put              = 1'b0;
    put_char         = CHAR_NONE;
    put_last         = 1'b0;
    put_uns          = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (s_axis_tdata == WORD_FALSE || s_axis_tdata == WORD_NULL ||
              s_axis_tdata == WORD_TRUE) begin
            state_next = S_TEXT;
          end else if (s_axis_tdata[2:0] == TAG_NUMBER) begin
            ctrl.load  = 1'b1;
            state_next = S_CONV;
          end else begin
            put      = 1'b1;
            put_last = 1'b1;
            put_uns  = 1'b1;
          end
        end
      end
      S_CONV: begin
        if (!stat.busy) begin
          state_next = neg ? S_SIGN : S_DIG;
        end
      end
      S_SIGN: begin
        if (can_put) begin
          put        = 1'b1;
          put_char   = CHAR_MINUS;
          state_next = S_DIG;
        end
      end
      S_DIG: begin
        if (can_put) begin
          ctrl.shift_digit = 1'b1;
          put              = dig_show;
          put_char         = CHAR_ZERO | {4'd0, digit};
          put_last         = dig_last;
          if (dig_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_TEXT: begin
        if (can_put) begin
          put      = 1'b1;
          put_char = txt_char(txt_sel, txt_idx);
          put_last = (txt_idx == txt_last(txt_sel));
          if (put_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (put) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (put) begin
      m_axis_tdata <= put_char;
      m_axis_tlast <= put_last;
      m_axis_tuser <= put_uns;
    end
    if (accept) begin
      neg     <= field[NUMBER_BITS-1];
      ecnt    <= '0;
      started <= 1'b0;
      txt_idx <= 3'd0;
      if (s_axis_tdata == WORD_NULL) begin
        txt_sel <= TXT_NULL;
      end else if (s_axis_tdata == WORD_TRUE) begin
        txt_sel <= TXT_TRUE;
      end else begin
        txt_sel <= TXT_FALSE;
      end
    end else begin
      if (ctrl.shift_digit) begin
        ecnt    <= ecnt + EW'(1);
        started <= started | dig_show;
      end
      if (state == S_TEXT && can_put) begin
        txt_idx <= txt_idx + 3'd1;
      end
    end
  end

  a_busy_conv: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> state == S_CONV)
    else $error("converter busy outside conversion");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser && m_axis_tdata == CHAR_MINUS) |-> !m_axis_tlast)
    else $error("sign character marked last");

  a_uns_item: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == CHAR_NONE))
    else $error("malformed unsupported item");

endmodule

FILE: tb/sv/tvdt_text_checker.sv
module tvdt_text_checker
  import tvdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [63:0] in_word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_char,
  input  logic        out_last,
  input  logic        out_unsup,
  output int          errors,
  output int          pending
);

  localparam int NB   = NUMBER_BITS_DEF;
  localparam int MAXD = MAX_DIGITS_DEF;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       unsup;
  } text_item_t;

  text_item_t text_q[$];
  int         err_count = 0;

  task automatic predict_text(input logic [63:0] w);
    logic [63:0] mask;
    logic [63:0] fld;
    logic [63:0] mag;
    logic [3:0]  digs [MAXD];
    logic        neg;
    string       txt;
    int          cnt;
    int          total;
    int          k;
    begin
      txt = "";
      if (w == WORD_FALSE) txt = "false";
      else if (w == WORD_NULL) txt = "null";
      else if (w == WORD_TRUE) txt = "true";
      if (txt.len() != 0) begin
        for (k = 0; k < txt.len(); k++)
          text_q.push_back({txt[k], k == txt.len() - 1, 1'b0});
      end else if (w[2:0] != TAG_NUMBER) begin
        text_q.push_back({CHAR_NONE, 1'b1, 1'b1});
      end else begin
        mask = (64'd1 << NB) - 64'd1;
        fld  = (w >> 3) & mask;
        neg  = fld[NB-1];
        mag  = neg ? ((~fld + 64'd1) & mask) : fld;
        // least significant digit first, only the low MAXD digits kept
        cnt     = 1;
        digs[0] = 4'(mag % 10);
        mag     = mag / 10;
        while (mag != 0 && cnt < MAXD) begin
          digs[cnt] = 4'(mag % 10);
          mag       = mag / 10;
          cnt++;
        end
        total = cnt + int'(neg);
        if (neg) text_q.push_back({CHAR_MINUS, total == 1, 1'b0});
        for (k = cnt - 1; k >= 0; k--)
          text_q.push_back({CHAR_ZERO + {4'd0, digs[k]}, k == 0, 1'b0});
      end
    end
  endtask

  always @(posedge clk) begin : watch
    text_item_t got;
    text_item_t want;
    if (!rst) begin
      if (in_valid && in_ready) predict_text(in_word);
      if (out_valid && out_ready) begin
        got = {out_char, out_last, out_unsup};
        if (text_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected item: char %02h last %0b unsup %0b",
                     got.ch, got.last, got.unsup);
        end else begin
          want = text_q.pop_front();
          if (got !== want) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch: exp %02h/%0b/%0b got %02h/%0b/%0b",
                       want.ch, want.last, want.unsup, got.ch, got.last, got.unsup);
          end
        end
      end
    end
    errors  <= err_count;
    pending <= text_q.size();
  end

endmodule

FILE: tb/sv/tb.sv
module tb;
  import tvdt_pkg::*;

  localparam logic [63:0] WORD_UNDEF   = 64'd24;
  localparam logic [2:0]  TAG_VARIABLE = 3'd2;
  localparam logic [2:0]  TAG_STRING   = 3'd3;
  localparam logic [2:0]  TAG_FUNCTION = 3'd4;
  localparam logic [2:0]  TAG_SPARE_LO = 3'd5;
  localparam logic [2:0]  TAG_SPARE_HI = 3'd7;

  localparam int DIRECTED    = 22;
  localparam int RAND_ITEMS  = 258;
  localparam int SQUEEZE_AT  = 100;
  localparam int SQUEEZE_LEN = 30;
  localparam int DRAIN_AT    = 200;
  localparam int HOLD_CYCLES = 400;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  int errors;
  int pending;
  bit squeeze = 1'b0;

  tagged_value_to_decimal_text u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  tvdt_text_checker u_chk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_word   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .out_unsup (m_axis_tuser),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int gap_len(input int long_max);
    int r;
    begin
      r = $urandom_range(0, 99);
      if (r < 55) gap_len = 0;
      else if (r < 90) gap_len = $urandom_range(1, 3);
      else gap_len = $urandom_range(8, long_max);
    end
  endfunction

  function automatic logic [63:0] num_word(input logic [60:0] v);
    num_word = {v, TAG_NUMBER};
  endfunction

  task automatic send_word(input logic [63:0] w);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // receiver: random ready runs and gaps, one long hold-off during the squeeze
  initial begin : sink
    int run;
    int gap;
    bit held;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (squeeze && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 10);
      m_axis_tready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = gap_len(30);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : stim
    logic [63:0] w;
    logic [63:0] raw;
    logic [60:0] fld;
    int i;
    int sel;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIRECTED; i++) begin
      case (i)
        0:  w = WORD_FALSE;
        1:  w = WORD_NULL;
        2:  w = WORD_TRUE;
        3:  w = WORD_UNDEF;
        4:  w = {61'h0123_4567_89ab_cdef, TAG_VARIABLE};
        5:  w = {61'h1fed_cba9_8765_4321, TAG_STRING};
        6:  w = {61'h0, TAG_FUNCTION};
        7:  w = {61'h1555_5555_5555_5555, TAG_SPARE_LO};
        8:  w = {61'h0aaa_aaaa_aaaa_aaaa, TAG_SPARE_LO + 3'd1};
        9:  w = {61'h1fff_ffff_ffff_ffff, TAG_SPARE_HI};
        10: w = 64'h8000_0000_0000_0000;
        11: w = num_word(61'd0);
        12: w = num_word(61'd1);
        13: w = num_word(-61'd1);
        14: w = num_word(61'd9);
        15: w = num_word(61'd10);
        16: w = num_word(-61'd10);
        17: w = num_word(61'h0fff_ffff_ffff_ffff);
        18: w = num_word(61'h1000_0000_0000_0000);
        19: w = num_word(61'd1000000000000000000);
        20: w = num_word(-61'd999999999999999999);
        default: w = 64'd32;
      endcase
      send_word(w);
      pause(gap_len(12));
    end
    drain();

    for (i = 0; i < RAND_ITEMS; i++) begin
      sel = $urandom_range(0, 99);
      raw = {$urandom, $urandom};
      if (sel < 55) begin
        // spread the digit count by shifting the magnitude down
        fld = raw[60:0] >> $urandom_range(0, 60);
        if ($urandom_range(0, 1) == 1) fld = -fld;
        w = num_word(fld);
      end else if (sel < 67) begin
        case ($urandom_range(0, 2))
          0:       w = WORD_FALSE;
          1:       w = WORD_NULL;
          default: w = WORD_TRUE;
        endcase
      end else if (sel < 77) begin
        w = raw;
        if (w[2:0] == TAG_NUMBER) w[2:0] = TAG_STRING;
        if (sel == 76) w = WORD_UNDEF;
      end else begin
        w = raw;
      end
      if (i == SQUEEZE_AT) squeeze = 1'b1;
      send_word(w);
      if (i == DRAIN_AT) drain();
      else if (!(i >= SQUEEZE_AT && i < SQUEEZE_AT + SQUEEZE_LEN)) pause(gap_len(100));
    end
    drain();
    repeat (120) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
